/* src/ipwvs_pkg.sv */
// Shared types, constants and register map for the IR pulse-width vote steering block.
package ipwvs_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_W         = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int CNT_W         = 8;
  localparam int OUT_W         = 24;

  localparam logic [CFG_W-1:0] SHORT_LOW_RST  = 32'd4500;
  localparam logic [CFG_W-1:0] SHORT_HIGH_RST = 32'd5500;
  localparam logic [CFG_W-1:0] LONG_LOW_RST   = 32'd9500;
  localparam logic [CFG_W-1:0] LONG_HIGH_RST  = 32'd10500;
  localparam logic [CFG_W-1:0] THIRD_LOW_RST  = 32'd14500;
  localparam logic [CFG_W-1:0] THIRD_HIGH_RST = 32'd15500;
  localparam logic [CNT_W-1:0] WINDOW_LEN_RST = 8'd10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SHORT_LOW  = 3'd0,
    REG_SHORT_HIGH = 3'd1,
    REG_LONG_LOW   = 3'd2,
    REG_LONG_HIGH  = 3'd3,
    REG_THIRD_LOW  = 3'd4,
    REG_THIRD_HIGH = 3'd5,
    REG_WINDOW_LEN = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    CODE_STOP    = 2'd0,
    CODE_LEFT    = 2'd1,
    CODE_RIGHT   = 2'd2,
    CODE_FORWARD = 2'd3
  } drive_code_t;

  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] short_low;
    logic [CFG_W-1:0] short_high;
    logic [CFG_W-1:0] long_low;
    logic [CFG_W-1:0] long_high;
    logic [CFG_W-1:0] third_low;
    logic [CFG_W-1:0] third_high;
    logic [CNT_W-1:0] window_len;
  } cfg_t;

  typedef struct packed {
    logic is_short;
    logic is_long;
    logic is_third;
  } pulse_class_t;

  typedef struct packed {
    logic        emit;
    drive_code_t code;
    logic [CNT_W-1:0] short_total;
    logic [CNT_W-1:0] long_total;
  } vote_res_t;

endpackage

/* src/ir_pulse_width_vote_steering.sv */
// Top level of the IR pulse-width vote steering block.
//
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tdata: capture_time; tuser: mode
//  m_axis    out  tvalid/tready        tdata: drive_code, short_total, long_total
//  cfg       in   cfg_we (no wait)     cfg_addr = register index, cfg_wdata
//
// One beat per cycle in steady state while the output is not stalled. A beat
// is first held in the input register; pairing, classification and the window
// vote are then worked out in a single combinational pass and land in the
// output register.
// Reset (rst, synchronous) empties both registers, clears the pairing and
// window state and reloads all configuration registers with their defaults.
// A stalled output holds the input stage; s_axis_tready drops only when the
// input register is full and the output register holds an untaken beat.
module ir_pulse_width_vote_steering
  import ipwvs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF   // timer width, 16..32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [31:0] capture_time
  input  logic [0:0]            s_axis_tuser,   // [0] mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // [1:0] drive_code, [9:2] short_total,
                                                // [17:10] long_total, [23:18] zero
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  cfg_t                 cfg;
  vote_res_t            res;

  // input stage
  logic                 in_valid;
  logic                 in_mode;
  logic [TIME_BITS-1:0] in_time;

  // output stage
  logic                 out_valid;
  drive_code_t          out_code;
  logic [CNT_W-1:0]     out_short;
  logic [CNT_W-1:0]     out_long;

  logic out_free, advance, s_beat;

  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  ipwvs_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  ipwvs_vote #(.TIME_BITS(TIME_BITS)) u_vote (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .advance      (advance),
    .mode         (in_mode),
    .capture_time (in_time),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_beat) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // only the low TIME_BITS of the timer take part
  always_ff @(posedge clk) begin
    if (s_beat) begin
      in_mode <= s_axis_tuser[0];
      in_time <= s_axis_tdata[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_code  <= res.code;
      out_short <= res.short_total;
      out_long  <= res.long_total;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_W - 2 - 2*CNT_W)'(0), out_long, out_short, out_code};

endmodule

/* src/ipwvs_cfg.sv */
// Configuration register file for the pulse classifier and voting window.
module ipwvs_cfg
  import ipwvs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_ADDR_W-1:0] addr,
  input  logic [CFG_W-1:0]      wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_low  <= SHORT_LOW_RST;
      cfg.short_high <= SHORT_HIGH_RST;
      cfg.long_low   <= LONG_LOW_RST;
      cfg.long_high  <= LONG_HIGH_RST;
      cfg.third_low  <= THIRD_LOW_RST;
      cfg.third_high <= THIRD_HIGH_RST;
      cfg.window_len <= WINDOW_LEN_RST;
    end else if (we) begin
      unique case (addr)
        REG_SHORT_LOW:  cfg.short_low  <= wdata;
        REG_SHORT_HIGH: cfg.short_high <= wdata;
        REG_LONG_LOW:   cfg.long_low   <= wdata;
        REG_LONG_HIGH:  cfg.long_high  <= wdata;
        REG_THIRD_LOW:  cfg.third_low  <= wdata;
        REG_THIRD_HIGH: cfg.third_high <= wdata;
        REG_WINDOW_LEN: cfg.window_len <= wdata[CNT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

/* src/ipwvs_classify.sv */
// Pulse width classifier: short (exclusive bounds), long and third (inclusive bounds).
module ipwvs_classify
  import ipwvs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] width,
  input  cfg_t                 cfg,
  output pulse_class_t         cls
);

  logic [CFG_W-1:0] w;
  logic             in_short, in_long, in_third;

  assign w        = CFG_W'(width);
  assign in_short = (w > cfg.short_low) && (w < cfg.short_high);
  assign in_long  = (w >= cfg.long_low) && (w <= cfg.long_high);
  assign in_third = (w >= cfg.third_low) && (w <= cfg.third_high);

  // short wins over long, long over third
  assign cls.is_short = in_short;
  assign cls.is_long  = !in_short && in_long;
  assign cls.is_third = !in_short && !in_long && in_third;

endmodule

/* src/ipwvs_vote.sv */
// Edge pairing, window counters, supervision flag and steering decision.
module ipwvs_vote
  import ipwvs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 advance,   // item in the input stage is consumed
  input  logic                 mode,
  input  logic [TIME_BITS-1:0] capture_time,
  output vote_res_t            res
);

  logic                 edge_phase, edge_phase_next;
  logic [TIME_BITS-1:0] first_edge_time;
  logic [CNT_W-1:0]     fill_count, fill_count_next;
  logic [CNT_W-1:0]     short_count, short_count_next;
  logic [CNT_W-1:0]     long_count, long_count_next;
  logic                 window_done, window_done_next;

  logic [TIME_BITS-1:0] width;
  pulse_class_t         cls;
  logic                 hit;
  logic [CNT_W-1:0]     fill_inc, short_inc, long_inc, limit;
  logic                 full;

  assign width = capture_time - first_edge_time;

  ipwvs_classify #(.TIME_BITS(TIME_BITS)) u_classify (
    .width (width),
    .cfg   (cfg),
    .cls   (cls)
  );

  assign hit       = cls.is_short || cls.is_long || cls.is_third;
  assign fill_inc  = fill_count + CNT_W'(1);
  assign short_inc = (cls.is_short && short_count != '1) ? short_count + CNT_W'(1)
                                                          : short_count;
  assign long_inc  = (cls.is_long && long_count != '1) ? long_count + CNT_W'(1)
                                                        : long_count;
  assign limit     = (cfg.window_len == '0) ? CNT_W'(1) : cfg.window_len;
  assign full      = fill_inc >= limit;

  always_comb begin
    edge_phase_next  = edge_phase;
    fill_count_next  = fill_count;
    short_count_next = short_count;
    long_count_next  = long_count;
    window_done_next = window_done;
    res.emit         = 1'b0;
    res.code         = CODE_STOP;
    res.short_total  = '0;
    res.long_total   = '0;
    if (mode == MODE_TICK) begin
      res.emit         = !window_done;
      window_done_next = 1'b0;
    end else if (!edge_phase) begin
      edge_phase_next = 1'b1;
    end else begin
      edge_phase_next = 1'b0;
      if (hit) begin
        if (!full) begin
          fill_count_next  = fill_inc;
          short_count_next = short_inc;
          long_count_next  = long_inc;
        end else begin
          res.emit         = 1'b1;
          res.short_total  = short_inc;
          res.long_total   = long_inc;
          if (short_inc > long_inc)      res.code = CODE_LEFT;
          else if (long_inc > short_inc) res.code = CODE_RIGHT;
          else                           res.code = CODE_FORWARD;
          fill_count_next  = '0;
          short_count_next = '0;
          long_count_next  = '0;
          window_done_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_phase  <= 1'b0;
      fill_count  <= '0;
      short_count <= '0;
      long_count  <= '0;
      window_done <= 1'b0;
    end else if (advance) begin
      edge_phase  <= edge_phase_next;
      fill_count  <= fill_count_next;
      short_count <= short_count_next;
      long_count  <= long_count_next;
      window_done <= window_done_next;
    end
  end

  // reset value of the first timestamp is zero, as the behavior expects
  always_ff @(posedge clk) begin
    if (rst) begin
      first_edge_time <= '0;
    end else if (advance && mode == MODE_EDGE && !edge_phase) begin
      first_edge_time <= capture_time;
    end
  end

endmodule

/* src/ipwvs_checker.sv */
// Port-level checks for the IR pulse-width vote steering block, bound to the top level.
module ipwvs_checker
  import ipwvs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  logic [1:0]       code;
  logic [CNT_W-1:0] short_total, long_total;

  assign code        = m_axis_tdata[1:0];
  assign short_total = m_axis_tdata[9:2];
  assign long_total  = m_axis_tdata[17:10];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && code == CODE_STOP |-> short_total == '0 && long_total == '0)
    else $error("stop beat carries nonzero totals");

  a_vote: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (code == CODE_STOP) ||
      (code == CODE_LEFT && short_total > long_total) ||
      (code == CODE_RIGHT && long_total > short_total) ||
      (code == CODE_FORWARD && long_total == short_total))
    else $error("steering code disagrees with totals");

  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

bind ir_pulse_width_vote_steering ipwvs_checker u_ipwvs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/ipwvs_vote_checker.sv */
// Checker for the IR vote steering block: predicts each vote beat and compares it.
module ipwvs_vote_checker
  import ipwvs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [31:0] capture_time
  input  logic [0:0]            s_axis_tuser,   // [0] mode
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_W-1:0]      m_axis_tdata,   // [1:0] drive_code, [9:2] short_total,
                                                // [17:10] long_total, [23:18] zero
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    mismatches,
  output int                    votes_due
);

  localparam logic [31:0] TIME_MASK = 32'((64'd1 << TIME_BITS) - 64'd1);

  typedef struct packed {
    drive_code_t      code;
    logic [CNT_W-1:0] short_total;
    logic [CNT_W-1:0] long_total;
  } vote_t;

  cfg_t             bounds;
  logic             second_edge;
  logic [31:0]      first_stamp;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] n_short;
  logic [CNT_W-1:0] n_long;
  logic             window_closed;
  vote_t            pending_votes[$];

  task automatic clear_model();
    bounds.short_low  = SHORT_LOW_RST;
    bounds.short_high = SHORT_HIGH_RST;
    bounds.long_low   = LONG_LOW_RST;
    bounds.long_high  = LONG_HIGH_RST;
    bounds.third_low  = THIRD_LOW_RST;
    bounds.third_high = THIRD_HIGH_RST;
    bounds.window_len = WINDOW_LEN_RST;
    second_edge   = 1'b0;
    first_stamp   = '0;
    fill          = '0;
    n_short       = '0;
    n_long        = '0;
    window_closed = 1'b0;
    pending_votes.delete();
  endtask

  task automatic load_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_SHORT_LOW:  bounds.short_low  = val;
      REG_SHORT_HIGH: bounds.short_high = val;
      REG_LONG_LOW:   bounds.long_low   = val;
      REG_LONG_HIGH:  bounds.long_high  = val;
      REG_THIRD_LOW:  bounds.third_low  = val;
      REG_THIRD_HIGH: bounds.third_high = val;
      REG_WINDOW_LEN: bounds.window_len = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic classify_and_vote(input logic md, input logic [31:0] stamp);
    logic [31:0]      width;
    logic             hit;
    logic [CNT_W-1:0] limit;
    vote_t            v;
    if (md == MODE_TICK) begin
      // stop only when no window closed since the previous tick
      if (!window_closed) begin
        v.code        = CODE_STOP;
        v.short_total = '0;
        v.long_total  = '0;
        pending_votes.push_back(v);
      end
      window_closed = 1'b0;
    end else if (!second_edge) begin
      first_stamp = stamp & TIME_MASK;
      second_edge = 1'b1;
    end else begin
      second_edge = 1'b0;
      width = ((stamp & TIME_MASK) - first_stamp) & TIME_MASK;
      hit   = 1'b1;
      limit = (bounds.window_len == '0) ? CNT_W'(1) : bounds.window_len;
      // short wins over long, long over third
      if (width > bounds.short_low && width < bounds.short_high)
        n_short = bump(n_short);
      else if (width >= bounds.long_low && width <= bounds.long_high)
        n_long = bump(n_long);
      else if (width >= bounds.third_low && width <= bounds.third_high)
        hit = 1'b1;
      else
        hit = 1'b0;
      if (hit) begin
        fill = fill + 1'b1;
        if (fill >= limit) begin
          if (n_short > n_long)
            v.code = CODE_LEFT;
          else if (n_long > n_short)
            v.code = CODE_RIGHT;
          else
            v.code = CODE_FORWARD;
          v.short_total = n_short;
          v.long_total  = n_long;
          pending_votes.push_back(v);
          fill          = '0;
          n_short       = '0;
          n_long        = '0;
          window_closed = 1'b1;
        end
      end
    end
  endtask

  task automatic check_vote(input logic [OUT_W-1:0] beat);
    vote_t want;
    if (pending_votes.size() == 0) begin
      $error("unexpected vote beat: drive_code %0d short_total %0d long_total %0d",
             beat[1:0], beat[9:2], beat[17:10]);
      mismatches++;
    end else begin
      want = pending_votes.pop_front();
      if (beat[1:0] !== want.code) begin
        $error("drive_code: expected %0d, got %0d", want.code, beat[1:0]);
        mismatches++;
      end
      if (beat[9:2] !== want.short_total) begin
        $error("short_total: expected %0d, got %0d", want.short_total, beat[9:2]);
        mismatches++;
      end
      if (beat[17:10] !== want.long_total) begin
        $error("long_total: expected %0d, got %0d", want.long_total, beat[17:10]);
        mismatches++;
      end
      if (beat[OUT_W-1:18] !== '0) begin
        $error("pad: expected 0, got %0d", beat[OUT_W-1:18]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
    end else begin
      // a result leaves only after its input has passed the input register, so check before predicting
      if (m_axis_tvalid && m_axis_tready) check_vote(m_axis_tdata);
      if (cfg_we) load_reg(cfg_addr, cfg_wdata);
      if (s_axis_tvalid && s_axis_tready) classify_and_vote(s_axis_tuser[0], s_axis_tdata);
    end
    votes_due = pending_votes.size();
  end

endmodule

/* sim/ir_pulse_width_vote_steering_tb.sv */
// Top of the IR pulse-width vote steering regression: stimulus, flow control and verdict.
module ir_pulse_width_vote_steering_tb;
  import ipwvs_pkg::*;

  localparam int NUM_REGS       = REG_WINDOW_LEN + 1;
  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before the run is failed
  localparam int SQUEEZE_CYCLES = 400;   // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES  = 4;     // pipeline drain margin before a reg write
  localparam int NUM_PHASES     = 10;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;   // [31:0] capture_time
  logic [0:0]            s_axis_tuser;   // [0] mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_W-1:0]      m_axis_tdata;   // [1:0] drive_code, [9:2] short_total,
                                         // [17:10] long_total, [23:18] zero
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;

  int mismatches;
  int votes_due;

  // shadow of the register contents, used to aim pulse widths at the classes
  logic [CFG_W-1:0] cur_reg [NUM_REGS];

  int   src_calm;
  int   sink_calm;
  int   beats_sent;
  logic half_open;      // one edge of a pair is in flight
  logic squeeze_req;
  logic squeeze_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ir_pulse_width_vote_steering dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  ipwvs_vote_checker vote_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .votes_due     (votes_due)
  );

  // Gap lengths: mostly none, some short, a few long; now and then a calm
  // stretch with no gaps at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // uniform value in [lo, hi]; lo when the range is empty
  function automatic logic [31:0] pick_in(input logic [31:0] lo, input logic [31:0] hi);
    logic [63:0] span;
    logic [63:0] r;
    if (hi < lo) return lo;
    span = {32'd0, hi} - {32'd0, lo} + 64'd1;
    r    = {$urandom, $urandom} % span;
    return lo + r[31:0];
  endfunction

  // Width aimed at one of the classes, at a class edge, or anywhere.
  function automatic logic [31:0] pick_width(input int short_pct);
    logic [31:0] s_lo;
    logic [31:0] s_hi;
    int          k;
    s_lo = cur_reg[REG_SHORT_LOW];
    s_hi = cur_reg[REG_SHORT_HIGH];
    if ($urandom_range(0, 99) < short_pct) begin
      // short bounds are exclusive: interior exists only if hi > lo + 1
      if ({1'b0, s_hi} > {1'b0, s_lo} + 33'd1) return pick_in(s_lo + 1, s_hi - 1);
      return $urandom;
    end
    k = $urandom_range(0, 9);
    if (k < 4) return pick_in(cur_reg[REG_LONG_LOW], cur_reg[REG_LONG_HIGH]);
    if (k < 6) return pick_in(cur_reg[REG_THIRD_LOW], cur_reg[REG_THIRD_HIGH]);
    if (k < 8) begin
      case ($urandom_range(0, 9))
        0:       return s_lo;
        1:       return s_hi;
        2:       return cur_reg[REG_LONG_LOW] - 1;
        3:       return cur_reg[REG_LONG_HIGH] + 1;
        4:       return cur_reg[REG_THIRD_LOW] - 1;
        5:       return cur_reg[REG_THIRD_HIGH] + 1;
        6:       return cur_reg[REG_LONG_LOW];
        7:       return cur_reg[REG_LONG_HIGH];
        8:       return cur_reg[REG_THIRD_LOW];
        default: return cur_reg[REG_THIRD_HIGH];
      endcase
    end
    return $urandom;
  endfunction

  // One input beat: optional gap, then hold tvalid until the beat is taken.
  task automatic send_beat(input logic md, input logic [31:0] stamp);
    int gap;
    gap = pick_gap(src_calm);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = md;
    s_axis_tdata  = stamp;
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
  endtask

  // Well-formed edge pair; a stray edge left open is closed off first.
  task automatic send_pair(input logic [31:0] first, input logic [31:0] width);
    if (half_open) begin
      send_beat(MODE_EDGE, $urandom);
      half_open = 1'b0;
    end
    send_beat(MODE_EDGE, first);
    send_beat(MODE_EDGE, first + width);
  endtask

  // Writes every register from the shadow, one per cycle.
  task automatic program_regs();
    for (int i = REG_SHORT_LOW; i <= REG_WINDOW_LEN; i++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_addr  = CFG_ADDR_W'(i);
      cfg_wdata = cur_reg[i];
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Sender pauses until every expected vote has come out, then lets the
  // pipeline drain of result-free beats.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (votes_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic choose_setting(input int p);
    case (p)
      0: begin
        // reset ranges, mid-size window
        cur_reg[REG_SHORT_LOW]  = SHORT_LOW_RST;
        cur_reg[REG_SHORT_HIGH] = SHORT_HIGH_RST;
        cur_reg[REG_LONG_LOW]   = LONG_LOW_RST;
        cur_reg[REG_LONG_HIGH]  = LONG_HIGH_RST;
        cur_reg[REG_THIRD_LOW]  = THIRD_LOW_RST;
        cur_reg[REG_THIRD_HIGH] = THIRD_HIGH_RST;
        cur_reg[REG_WINDOW_LEN] = 32'd7;
      end
      1: begin
        // everything wide open, window length zero acts as one
        cur_reg[REG_SHORT_LOW]  = 32'h0000_0000;
        cur_reg[REG_SHORT_HIGH] = 32'hFFFF_FFFF;
        cur_reg[REG_LONG_LOW]   = 32'h0000_0000;
        cur_reg[REG_LONG_HIGH]  = 32'hFFFF_FFFF;
        cur_reg[REG_THIRD_LOW]  = 32'h0000_0000;
        cur_reg[REG_THIRD_HIGH] = 32'hFFFF_FFFF;
        cur_reg[REG_WINDOW_LEN] = 32'd0;
      end
      2: begin
        // no short class, long only at the very top, junk above the window byte
        cur_reg[REG_SHORT_LOW]  = 32'hFFFF_FFFF;
        cur_reg[REG_SHORT_HIGH] = 32'h0000_0000;
        cur_reg[REG_LONG_LOW]   = 32'hFFFF_FFFF;
        cur_reg[REG_LONG_HIGH]  = 32'hFFFF_FFFF;
        cur_reg[REG_THIRD_LOW]  = 32'h0000_0000;
        cur_reg[REG_THIRD_HIGH] = 32'h0000_3FFF;
        cur_reg[REG_WINDOW_LEN] = {24'($urandom_range(0, 32'hFF_FFFF)), 8'd1};
      end
      3: begin
        // longest window with only the short class live: counts top out at 255
        cur_reg[REG_SHORT_LOW]  = SHORT_LOW_RST;
        cur_reg[REG_SHORT_HIGH] = SHORT_HIGH_RST;
        cur_reg[REG_LONG_LOW]   = 32'hFFFF_FFFF;
        cur_reg[REG_LONG_HIGH]  = 32'h0000_0000;
        cur_reg[REG_THIRD_LOW]  = 32'hFFFF_FFFF;
        cur_reg[REG_THIRD_HIGH] = 32'h0000_0000;
        cur_reg[REG_WINDOW_LEN] = 32'd255;
      end
      default: begin
        // random, often overlapping ranges so the class priority matters
        cur_reg[REG_SHORT_LOW]  = $urandom_range(0, 20000);
        cur_reg[REG_SHORT_HIGH] = cur_reg[REG_SHORT_LOW] + $urandom_range(0, 4000);
        cur_reg[REG_LONG_LOW]   = $urandom_range(0, 30000);
        cur_reg[REG_LONG_HIGH]  = cur_reg[REG_LONG_LOW] + $urandom_range(0, 6000);
        cur_reg[REG_THIRD_LOW]  = $urandom_range(0, 40000);
        cur_reg[REG_THIRD_HIGH] = cur_reg[REG_THIRD_LOW] + $urandom_range(0, 6000);
        if ($urandom_range(0, 3) == 0) cur_reg[REG_THIRD_HIGH] = $urandom;
        cur_reg[REG_WINDOW_LEN] = $urandom_range(1, 12);
      end
    endcase
  endtask

  // Mostly well-formed pairs; some ticks and stray edges that break the pairing.
  task automatic run_phase(input int n_beats, input int short_pct);
    int          stop_at;
    int          r;
    logic [31:0] first;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_beat(MODE_TICK, $urandom);
      end else if (r < 12) begin
        send_beat(MODE_EDGE, $urandom);
        half_open = ~half_open;
      end else begin
        first = $urandom;
        send_pair(first, pick_width(short_pct));
      end
    end
  endtask

  // Receiver: random tready gaps, plus one long hold-off on request.
  initial begin
    int gap;
    int hold;
    m_axis_tready = 1'b0;
    squeeze_done  = 1'b0;
    sink_calm     = 0;
    hold          = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else if (squeeze_req && !squeeze_done) begin
        squeeze_done  = 1'b1;
        hold          = SQUEEZE_CYCLES - 1;
        m_axis_tready = 1'b0;
      end else begin
        gap = pick_gap(sink_calm);
        if (gap > 0) begin
          hold          = gap - 1;
          m_axis_tready = 1'b0;
        end else begin
          m_axis_tready = 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("ir_pulse_width_vote_steering regression: fail");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_EDGE;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    src_calm      = 0;
    beats_sent    = 0;
    half_open     = 1'b0;
    squeeze_req   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: reset ranges, window of three pulses.
    choose_setting(0);
    cur_reg[REG_WINDOW_LEN] = 32'd3;
    program_regs();
    send_beat(MODE_TICK, 32'hFFFF_FFFF);    // no window yet: stop
    send_pair(32'h0000_0000, 32'd4500);     // on the exclusive short bound: ignored
    send_pair($urandom, 32'd4501);          // short
    send_pair($urandom, 32'd5500);          // upper short bound: ignored
    send_pair(32'hFFFF_FF00, 32'd5499);     // short across a timer wrap
    send_pair($urandom, 32'd10500);         // long, window full: left 2/1
    send_beat(MODE_TICK, 32'h0000_0000);    // window done: silent, flag cleared
    send_beat(MODE_TICK, $urandom);         // flag gone: stop
    send_pair($urandom, 32'd15500);         // third, counts toward fill only
    send_pair($urandom, 32'd9500);          // long
    send_pair(32'hFFFF_FFFF, 32'd14500);    // third, window full: right 0/1
    send_pair($urandom, 32'd9499);          // just under long: ignored
    send_pair(32'h0000_0000, 32'd0);        // zero width: ignored
    settle();

    // Random part, one register setting per phase. Phase ends leave windows
    // half filled, so the next setting may find the fill above a shorter window.
    for (int p = 0; p < NUM_PHASES; p++) begin
      choose_setting(p);
      program_regs();
      if (p == 1) squeeze_req = 1'b1;   // nearly every pair votes here
      case (p)
        0, 1, 2: run_phase(150, 30);
        3:       run_phase(720, 95);
        default: run_phase(110, 30);
      endcase
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && votes_due == 0)
      $display("ir_pulse_width_vote_steering regression: pass");
    else
      $display("ir_pulse_width_vote_steering regression: fail");
    $finish;
  end

endmodule
